// ===== rtl/core/mclm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the lockup monitor.
package mclm_pkg;

  localparam int NUM_CPUS  = 8;
  localparam int CPU_W     = $clog2(NUM_CPUS);
  localparam int TIME_BITS = 32;
  localparam int BEAT_W    = 32;
  localparam int HT_W      = 8;
  localparam int REQ_W     = 3;
  localparam int MASK_W    = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC_ENABLE = CFG_IDX_W'(1);
  localparam logic [HT_W-1:0]      HALF_TIMEOUT_RST = HT_W'(10);

  localparam logic [REQ_W-1:0] REQ_CHECK     = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_HEARTBEAT = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_TOUCH     = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_ENABLE    = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_DISABLE   = REQ_W'(4);

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = REQ_W;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic             capture;
    logic             apply;
    logic             scan_step;
    logic [CPU_W-1:0] scan_idx;
    logic             load_out;
  } mclm_cmd_t;

  typedef struct packed {
    logic is_check;
    logic checks_on;
    logic scan_stop;
    logic panic_flag;
  } mclm_sts_t;

endpackage

// ===== rtl/core/mclm_ctrl.sv =====
// Sequencing state machine of the lockup monitor: accept, decode, scan, deliver.
module mclm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  mclm_pkg::mclm_sts_t sts,
  output mclm_pkg::mclm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [mclm_pkg::CPU_W-1:0] LAST_IDX = mclm_pkg::CPU_W'(mclm_pkg::NUM_CPUS - 1);
  localparam logic [mclm_pkg::CPU_W-1:0] IDX_ONE  = mclm_pkg::CPU_W'(1);

  logic [1:0]                 state_r, state_nxt;
  logic [mclm_pkg::CPU_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.scan_idx  = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.apply = !sts.is_check;
        idx_nxt   = '0;
        state_nxt = (sts.is_check && sts.checks_on) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_stop || idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_ONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/mclm_dp.sv =====
// Datapath of the lockup monitor: per-CPU state, scan step logic, config and result registers.
module mclm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mclm_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [mclm_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                 cfg_valid,
  input  logic [mclm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mclm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [mclm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  mclm_pkg::mclm_cmd_t                  cmd,
  output mclm_pkg::mclm_sts_t                  sts
);

  localparam int NC = mclm_pkg::NUM_CPUS;
  localparam int TW = mclm_pkg::TIME_BITS;
  localparam int BW = mclm_pkg::BEAT_W;
  localparam int CW = mclm_pkg::CPU_W;
  localparam int MW = mclm_pkg::MASK_W;

  localparam logic [BW-1:0] BEAT_ONE = BW'(1);

  logic [mclm_pkg::HT_W-1:0]  half_timeout_r;
  logic                       panic_enable_r;
  logic [NC-1:0]              enabled_r;
  logic [NC-1:0]              pending_r;
  logic [NC-1:0]              warned_r;
  logic [TW-1:0]              touch_time_r [NC];
  logic [BW-1:0]              beat_count_r [NC];
  logic [BW-1:0]              beat_saved_r [NC];
  logic                       panic_flag_r;

  logic [mclm_pkg::REQ_W-1:0] req_r;
  logic [CW-1:0]              cpu_r;
  logic                       tval_r;
  logic [TW-1:0]              now_r;
  logic [CW-1:0]              local_r;
  logic [MW-1:0]              online_r;

  logic [MW-1:0]              warn_acc_r;
  logic                       raised_r;
  logic [CW-1:0]              pcpu_r;
  logic [mclm_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [CW-1:0] sel;
  logic [TW-1:0] tt_sel, window, deadline, diff;
  logic          eligible, expired, stalled;
  logic          do_consume, do_seed, do_expire, do_panic, do_warn, do_rearm;

  assign sel      = cmd.scan_step ? cmd.scan_idx : cpu_r;
  assign tt_sel   = touch_time_r[sel];
  assign window   = TW'({half_timeout_r, 1'b0});
  assign deadline = tt_sel + window;
  assign diff     = deadline - now_r;
  assign expired  = diff[TW-1];
  assign stalled  = (beat_saved_r[sel] == beat_count_r[sel]);
  assign eligible = enabled_r[sel] && online_r[sel] && (sel != local_r);

  assign do_consume = eligible && pending_r[sel];
  assign do_seed    = eligible && !pending_r[sel] && (tt_sel == '0);
  assign do_expire  = eligible && !pending_r[sel] && (tt_sel != '0) && expired;
  assign do_panic   = do_expire && stalled && !warned_r[sel] && panic_enable_r;
  assign do_warn    = do_expire && stalled && !warned_r[sel] && !panic_enable_r;
  assign do_rearm   = do_expire && !stalled;

  assign sts.is_check   = (req_r == mclm_pkg::REQ_CHECK);
  assign sts.checks_on  = (half_timeout_r != '0);
  assign sts.scan_stop  = cmd.scan_step && do_panic;
  assign sts.panic_flag = panic_flag_r;

  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_timeout_r <= mclm_pkg::HALF_TIMEOUT_RST;
      panic_enable_r <= 1'b0;
      enabled_r      <= '0;
      pending_r      <= '0;
      warned_r       <= '0;
      panic_flag_r   <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        touch_time_r[i] <= '0;
        beat_count_r[i] <= '0;
        beat_saved_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == mclm_pkg::CFG_HALF_TIMEOUT) begin
          half_timeout_r <= cfg_data[mclm_pkg::HT_W-1:0];
        end else if (cfg_index == mclm_pkg::CFG_PANIC_ENABLE) begin
          panic_enable_r <= cfg_data[0];
        end
      end
      if (cmd.apply) begin
        unique case (req_r)
          mclm_pkg::REQ_HEARTBEAT: beat_count_r[sel] <= beat_count_r[sel] + BEAT_ONE;
          mclm_pkg::REQ_TOUCH:     pending_r[sel]    <= tval_r;
          mclm_pkg::REQ_ENABLE: begin
            enabled_r[sel]    <= 1'b1;
            touch_time_r[sel] <= '0;
          end
          mclm_pkg::REQ_DISABLE: begin
            enabled_r[sel]    <= 1'b0;
            touch_time_r[sel] <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.scan_step) begin
        if (do_consume) begin
          pending_r[sel] <= 1'b0;
        end
        if (do_seed || do_expire) begin
          touch_time_r[sel] <= now_r;
        end
        if (do_panic) begin
          panic_flag_r <= 1'b1;
        end
        if (do_warn) begin
          warned_r[sel] <= 1'b1;
        end
        if (do_rearm) begin
          beat_saved_r[sel] <= beat_count_r[sel];
          warned_r[sel]     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= in_tuser[mclm_pkg::REQ_W-1:0];
      cpu_r      <= in_tdata[2:0];
      tval_r     <= in_tdata[3];
      now_r      <= in_tdata[35:4];
      local_r    <= in_tdata[38:36];
      online_r   <= in_tdata[46:39];
      warn_acc_r <= '0;
      raised_r   <= 1'b0;
      pcpu_r     <= '0;
    end else if (cmd.scan_step) begin
      if (do_warn) begin
        warn_acc_r[sel] <= 1'b1;
      end
      if (do_panic) begin
        raised_r <= 1'b1;
        pcpu_r   <= sel;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= {3'b000, panic_flag_r, pcpu_r, raised_r, warn_acc_r};
    end
  end

endmodule

// ===== rtl/core/multi_cpu_hard_lockup_monitor_top.sv =====
// Multi-CPU hard lockup monitor: one request in, one result out per request. A request
// passes through decode and, for a check tick with checks enabled, an eight-step scan
// (one CPU per step, fewer when a panic ends it) before its result is loaded; the scan is
// run by the one shared step unit that visits the per-CPU state registers in turn. A new request
// is taken once the previous result sits in the output register; configuration writes
// are taken at any time and must only be issued while no request is in flight.
module multi_cpu_hard_lockup_monitor_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // cpu_index[2:0], touch_value[3], now_seconds[35:4], home_cpu[38:36],
  // online_mask[46:39], zero[47]
  input  logic [mclm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // req_type[2:0]
  input  logic [mclm_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // warn_mask[7:0], panic_raised[8], panic_cpu[11:9], panic_latched[12], zero[15:13]
  output logic [mclm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mclm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mclm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mclm_pkg::mclm_cmd_t cmd;
  mclm_pkg::mclm_sts_t sts;

  assign cfg_ready = 1'b1;

  mclm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mclm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  a_panic_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.panic_flag |=> sts.panic_flag)
    else $error("panic latch cleared");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.apply && cmd.scan_step))
    else $error("update and scan step in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while one is in flight");

  a_raised_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> out_tdata[12])
    else $error("panic reported without latch");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the multi-CPU hard lockup monitor: stream stimulus and a scoreboard.
`timescale 1ns / 1ps

import mclm_pkg::*;

typedef struct {
  logic [REQ_W-1:0]     kind;
  logic [CPU_W-1:0]     cpu;
  logic                 touch;
  logic [TIME_BITS-1:0] now;
  logic [CPU_W-1:0]     home_cpu;
  logic [MASK_W-1:0]    online;
} lockup_req_t;

typedef struct {
  logic [MASK_W-1:0] warn;
  logic              raised;
  logic [CPU_W-1:0]  cpu;
  logic              latched;
} lockup_verdict_t;

class lockup_scoreboard;
  bit [HT_W-1:0]      half_to;
  bit                 panic_en;
  bit [NUM_CPUS-1:0]  enabled;
  bit                 touch_pend [NUM_CPUS];
  bit [TIME_BITS-1:0] stamp [NUM_CPUS];
  bit [BEAT_W-1:0]    beats [NUM_CPUS];
  bit [BEAT_W-1:0]    beats_seen [NUM_CPUS];
  bit                 warned [NUM_CPUS];
  bit                 latched;
  lockup_verdict_t    verdict_q [$];
  int                 errors;

  function new();
    half_to  = HALF_TIMEOUT_RST;
    panic_en = 1'b0;
    enabled  = '0;
    latched  = 1'b0;
    errors   = 0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      touch_pend[c] = 1'b0;
      stamp[c]      = '0;
      beats[c]      = '0;
      beats_seen[c] = '0;
      warned[c]     = 1'b0;
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction

  function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_HALF_TIMEOUT) half_to = val[HT_W-1:0];
    else if (idx == CFG_PANIC_ENABLE) panic_en = val[0];
  endfunction

  task report(string msg);
    errors++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  // scan the watched CPUs on a check tick with checks enabled, or update one CPU's state
  function void note_request(lockup_req_t r);
    lockup_verdict_t    v;
    bit [TIME_BITS-1:0] window;
    bit [TIME_BITS-1:0] lead;
    int                 c;
    v = '{warn: '0, raised: 1'b0, cpu: '0, latched: 1'b0};
    if (r.kind == REQ_CHECK) begin
      if (half_to != 0) begin
        window = TIME_BITS'(half_to) << 1;
        for (c = 0; c < NUM_CPUS && c < MASK_W; c++) begin
          if (!enabled[c] || !r.online[c] || c == int'(r.home_cpu)) continue;
          if (touch_pend[c]) begin
            touch_pend[c] = 1'b0;
            continue;
          end
          if (stamp[c] == 0) begin
            stamp[c] = r.now;
            continue;
          end
          lead = stamp[c] + window - r.now;
          if (!lead[TIME_BITS-1]) continue;
          stamp[c] = r.now;
          if (beats_seen[c] == beats[c]) begin
            if (warned[c]) continue;
            if (panic_en) begin
              latched  = 1'b1;
              v.raised = 1'b1;
              v.cpu    = CPU_W'(c);
              break;
            end
            v.warn[c] = 1'b1;
            warned[c] = 1'b1;
          end else begin
            beats_seen[c] = beats[c];
            warned[c]     = 1'b0;
          end
        end
      end
    end else if (int'(r.cpu) < NUM_CPUS) begin
      case (r.kind)
        REQ_HEARTBEAT: beats[r.cpu] = beats[r.cpu] + BEAT_W'(1);
        REQ_TOUCH:     touch_pend[r.cpu] = r.touch;
        REQ_ENABLE: begin
          enabled[r.cpu] = 1'b1;
          stamp[r.cpu]   = '0;
        end
        REQ_DISABLE: begin
          enabled[r.cpu] = 1'b0;
          stamp[r.cpu]   = '0;
        end
        default: ;
      endcase
    end
    v.latched = latched;
    verdict_q.push_back(v);
  endfunction

  task check_result(logic [OUT_TDATA_W-1:0] d);
    lockup_verdict_t want;
    if (verdict_q.size() == 0) begin
      report($sformatf("result %h with nothing expected", d));
      return;
    end
    want = verdict_q.pop_front();
    if (d[7:0] !== want.warn)
      report($sformatf("warn_mask %h, expected %h", d[7:0], want.warn));
    if (d[8] !== want.raised)
      report($sformatf("panic_raised %b, expected %b", d[8], want.raised));
    if (d[11:9] !== want.cpu)
      report($sformatf("panic_cpu %0d, expected %0d", d[11:9], want.cpu));
    if (d[12] !== want.latched)
      report($sformatf("panic_latched %b, expected %b", d[12], want.latched));
  endtask

  task finish_check();
    if (verdict_q.size() != 0)
      report($sformatf("%0d results never arrived", verdict_q.size()));
  endtask
endclass

module tb;
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_AT        = 700;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [REQ_W-1:0] REQ_ODD_LO = REQ_DISABLE + REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_ODD_HI = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lockup_scoreboard   sb;
  bit                 calm;
  bit [TIME_BITS-1:0] clock_s;
  bit [NUM_CPUS-1:0]  busy;
  int                 cur_half;
  int                 idle_cycles;

  multi_cpu_hard_lockup_monitor_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic lockup_req_t request_of(logic [REQ_W-1:0] kind, logic [CPU_W-1:0] cpu,
                                             logic touch, logic [TIME_BITS-1:0] now,
                                             logic [CPU_W-1:0] home, logic [MASK_W-1:0] online);
    lockup_req_t r;
    r.kind     = kind;
    r.cpu      = cpu;
    r.touch    = touch;
    r.now      = now;
    r.home_cpu = home;
    r.online   = online;
    return r;
  endfunction

  task automatic offer_request(input lockup_req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {1'b0, r.online, r.home_cpu, r.now, r.touch, r.cpu};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
  endtask

  // hold the input until every outstanding result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_config(idx, val);
  endtask

  task automatic run_phase(input int half, input bit pen, input int count, input int drain_at);
    lockup_req_t r;
    int          pick;
    int          span;
    write_reg(CFG_HALF_TIMEOUT, CFG_DATA_W'(half));
    write_reg(CFG_PANIC_ENABLE, CFG_DATA_W'(pen));
    cur_half = half;
    busy     = NUM_CPUS'($urandom);
    clock_s  = ($urandom_range(0, 3) == 0) ? '1 - TIME_BITS'($urandom_range(0, 600))
                                            : TIME_BITS'($urandom);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == drain_at) drain();
      r = request_of(REQ_CHECK, CPU_W'($urandom), 1'($urandom), TIME_BITS'($urandom),
                     CPU_W'($urandom), MASK_W'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        span = 2 * cur_half;
        if ($urandom_range(0, 29) == 0)
          clock_s = TIME_BITS'($urandom);
        else if ($urandom_range(0, 4) == 0)
          clock_s = clock_s + TIME_BITS'($urandom_range(span / 2, span + 3));
        else
          clock_s = clock_s + TIME_BITS'($urandom_range(0, span / 4 + 1));
        r.now = clock_s;
        if ($urandom_range(0, 3) != 0) r.online = '1;
      end else if (pick < 70) begin
        r.kind = REQ_HEARTBEAT;
        repeat (3) if (!busy[r.cpu]) r.cpu = CPU_W'($urandom);
      end else if (pick < 80) begin
        r.kind = REQ_TOUCH;
      end else if (pick < 89) begin
        r.kind = REQ_ENABLE;
      end else if (pick < 94) begin
        r.kind = REQ_DISABLE;
      end else begin
        r.kind = REQ_W'($urandom_range(REQ_ODD_LO, REQ_ODD_HI));
      end
      offer_request(r);
    end
  endtask

  initial begin : result_sink
    int stall;
    int seen;
    seen = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (seen == HOLD_AT) stall = LONG_HOLD;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      seen++;
    end
  end

  initial begin
    sb          = new();
    calm        = 1'b0;
    idle_cycles = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(request_of(REQ_CHECK, 0, 0, 0, 0, '1));
    offer_request(request_of(REQ_ENABLE, 0, 0, '1, 7, 0));
    offer_request(request_of(REQ_ENABLE, 1, 1, 0, 0, '1));
    offer_request(request_of(REQ_ENABLE, 7, 0, 0, 0, 0));
    offer_request(request_of(REQ_ODD_LO, 2, 1, '1, 7, '1));
    offer_request(request_of(REQ_ODD_HI, 5, 0, 0, 0, 0));
    // a seed taken at time zero leaves the stamp unset
    offer_request(request_of(REQ_CHECK, 0, 0, 0, 7, '1));
    offer_request(request_of(REQ_CHECK, 0, 0, 1, 0, '1));
    offer_request(request_of(REQ_HEARTBEAT, 1, 0, 0, 0, 0));
    offer_request(request_of(REQ_TOUCH, 0, 1, 0, 0, 0));
    offer_request(request_of(REQ_TOUCH, 7, 1, '1, 7, '1));
    offer_request(request_of(REQ_TOUCH, 7, 0, 0, 0, 0));
    offer_request(request_of(REQ_CHECK, 0, 0, 32'hFFFF_FFF0, 3, 8'h00));
    offer_request(request_of(REQ_CHECK, 0, 0, 32'hFFFF_FFFF, 3, '1));
    offer_request(request_of(REQ_CHECK, 0, 0, 100, 3, '1));
    offer_request(request_of(REQ_CHECK, 0, 0, 200, 7, '1));
    offer_request(request_of(REQ_HEARTBEAT, 7, 1, '1, 7, '1));
    offer_request(request_of(REQ_HEARTBEAT, 0, 0, 0, 0, 0));
    offer_request(request_of(REQ_CHECK, 0, 0, 300, 3, '1));
    offer_request(request_of(REQ_DISABLE, 1, 0, 0, 0, 0));
    offer_request(request_of(REQ_HEARTBEAT, 1, 1, '1, 7, '1));
    offer_request(request_of(REQ_CHECK, 0, 0, 400, 2, 8'h81));

    run_phase(0, 1'b0, 60, -1);
    run_phase(1, 1'b1, 250, -1);
    run_phase(255, 1'b0, 150, -1);
    run_phase(2, 1'b0, 300, -1);
    run_phase(10, 1'b1, 300, 150);
    run_phase(3, 1'b0, 250, -1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
